// ----- rtl/rvlc_pkg.sv -----
// ----------------------------------------------------------------------------
// rvlc_pkg
// shared constants and types of the rvl depth compressor: run limits,
// value buffer geometry and the nibble packer interface
// ----------------------------------------------------------------------------
package rvlc_pkg;

  localparam int DEPTH_W    = 16;
  localparam int ZZ_W       = DEPTH_W + 1;
  localparam int ZRUN_W     = 22;
  localparam int VCNT_W     = 6;
  localparam int VBUF_DEPTH = 32;
  localparam int VBUF_AW    = $clog2(VBUF_DEPTH);
  localparam int NIB_DATA_W = 3;
  localparam int WORD_W     = 32;
  localparam int PART_W     = WORD_W - 4;

  localparam logic [VCNT_W-1:0] MAX_NONZERO_RUN = 6'd32;
  localparam logic [ZRUN_W-1:0] MAX_ZERO_RUN    = 22'h3FFFFF;
  localparam logic [2:0]        NIB_LAST_SLOT   = 3'd7;

  typedef struct packed {
    logic       put;
    logic [3:0] nib;
    logic       last;
  } nib_req_t;

  typedef struct packed {
    logic nib_ready;
    logic empty;
  } pack_status_t;

endpackage

// ----- rtl/rvlc_packer.sv -----
// ----------------------------------------------------------------------------
// rvlc_packer
// collects code nibbles most significant first, eight to a word, and holds
// the finished word in an output register until it is taken
// ----------------------------------------------------------------------------
module rvlc_packer import rvlc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  nib_req_t            req,
  output pack_status_t        status,
  output logic [WORD_W-1:0]   packed_word,
  output logic                last_word,
  output logic                word_valid,
  input  logic                word_stall
);

  logic [PART_W-1:0] partial;
  logic [2:0]        nib_count;
  logic              full;
  logic              take;

  assign full             = (nib_count == NIB_LAST_SLOT);
  assign status.nib_ready = !full || !word_valid || !word_stall;
  assign status.empty     = (nib_count == 3'd0);
  assign take             = req.put && status.nib_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
      nib_count  <= 3'd0;
      partial    <= '0;
    end else begin
      if (take && full) begin
        word_valid <= 1'b1;
      end else if (!word_stall) begin
        word_valid <= 1'b0;
      end
      if (take) begin
        if (full) begin
          partial    <= '0;
          nib_count  <= 3'd0;
        end else begin
          partial   <= {partial[PART_W-5:0], req.nib};
          nib_count <= nib_count + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && full) begin
      packed_word <= {partial, req.nib};
      last_word   <= req.last;
    end
  end

endmodule

// ----- rtl/rvl_depth_compressor_core.sv -----
// ----------------------------------------------------------------------------
// rvl_depth_compressor_core
// run length / variable length depth compressor: a sequencer walks each
// group through one shared 3-bit code shifter feeding the nibble packer
// a pixel that closes no group passes through the accept and apply states
// closing a group: a load and an emit per code, emit held per extra nibble, plus a
// fetch per buffered value; stalls on the word channel hold the emit state
// frame end adds the final group, zero fill nibbles up to the word boundary and a return to idle
// reset: synchronous, clears runs, previous value and packer; buffer is not
// cleared
// ----------------------------------------------------------------------------
module rvl_depth_compressor_core import rvlc_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic signed [DEPTH_W-1:0] depth,
  input  logic                      last_pixel,
  input  logic                      pixel_valid,
  output logic                      pixel_stall,
  output logic [WORD_W-1:0]         packed_word,
  output logic                      last_word,
  output logic                      word_valid,
  input  logic                      word_stall
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_APPLY = 6'b000010,
    S_LOAD  = 6'b000100,
    S_EMIT  = 6'b001000,
    S_FETCH = 6'b010000,
    S_FLUSH = 6'b100000
  } state_t;

  typedef enum logic [2:0] {
    PH_ZERO  = 3'b001,
    PH_COUNT = 3'b010,
    PH_VAL   = 3'b100
  } phase_t;

  state_t                   state;
  phase_t                   phase;
  logic signed [DEPTH_W-1:0] pix;
  logic                     last_in;
  logic                     grp_final;
  logic signed [DEPTH_W-1:0] prev;
  logic [ZRUN_W-1:0]        zero_run;
  logic [VCNT_W-1:0]        count;
  logic [VBUF_AW-1:0]       idx;
  logic [ZRUN_W-1:0]        cur;
  logic [ZZ_W-1:0]          rd_data;
  logic [ZZ_W-1:0]          vbuf [VBUF_DEPTH];

  logic                     accept;
  logic                     pre_emit;
  logic                     code_end;
  logic                     final_code;
  logic [VCNT_W-1:0]        cnt_m1;
  logic signed [ZZ_W-1:0]   delta;
  logic [ZZ_W-1:0]          zz;
  logic                     vbuf_we;
  nib_req_t                 req;
  pack_status_t             st;

  assign pixel_stall = (state != S_IDLE);
  assign accept      = pixel_valid && !pixel_stall;

  assign pre_emit = (depth == '0) ? ((count != '0) || (zero_run >= MAX_ZERO_RUN))
                                  : (count >= MAX_NONZERO_RUN);

  assign code_end   = (cur[ZRUN_W-1:NIB_DATA_W] == '0);
  assign cnt_m1     = count - 6'd1;
  assign final_code = ((phase == PH_COUNT) && (count == '0)) ||
                      ((phase == PH_VAL) && ({1'b0, idx} == cnt_m1));

  // zigzag of the difference to the previous nonzero pixel
  assign delta   = ZZ_W'(pix) - ZZ_W'(prev);
  assign zz      = {delta[ZZ_W-2:0], 1'b0} ^ {ZZ_W{delta[ZZ_W-1]}};
  assign vbuf_we = (state == S_APPLY) && (pix != '0);

  always_comb begin
    req = '0;
    if (state == S_EMIT) begin
      req.put  = 1'b1;
      req.nib  = {!code_end, cur[NIB_DATA_W-1:0]};
      req.last = grp_final && code_end && final_code;
    end else if (state == S_FLUSH && !st.empty) begin
      req.put  = 1'b1;
      req.nib  = 4'd0;
      req.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (vbuf_we) begin
      vbuf[count[VBUF_AW-1:0]] <= zz;
    end
    rd_data <= vbuf[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= PH_ZERO;
      grp_final <= 1'b0;
      prev      <= '0;
      zero_run  <= '0;
      count     <= '0;
      idx       <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            grp_final <= 1'b0;
            phase     <= PH_ZERO;
            state     <= pre_emit ? S_LOAD : S_APPLY;
          end
        end
        S_APPLY: begin
          if (pix == '0) begin
            zero_run <= zero_run + 22'd1;
          end else begin
            count <= count + 6'd1;
            prev  <= pix;
          end
          if (last_in) begin
            grp_final <= 1'b1;
            phase     <= PH_ZERO;
            state     <= S_LOAD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_LOAD: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (st.nib_ready && code_end) begin
            if (final_code) begin
              zero_run <= '0;
              count    <= '0;
              state    <= grp_final ? S_FLUSH : S_APPLY;
            end else begin
              unique case (phase)
                PH_ZERO: begin
                  phase <= PH_COUNT;
                  state <= S_LOAD;
                end
                PH_COUNT: begin
                  phase <= PH_VAL;
                  idx   <= '0;
                  state <= S_FETCH;
                end
                PH_VAL: begin
                  idx   <= idx + 5'd1;
                  state <= S_FETCH;
                end
                default: state <= S_LOAD;
              endcase
            end
          end
        end
        S_FETCH: begin
          state <= S_LOAD;
        end
        S_FLUSH: begin
          if (st.empty) begin
            prev      <= '0;
            zero_run  <= '0;
            count     <= '0;
            grp_final <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      pix     <= depth;
      last_in <= last_pixel;
    end
    if (state == S_LOAD) begin
      case (phase)
        PH_ZERO:  cur <= zero_run;
        PH_COUNT: cur <= ZRUN_W'(count);
        default:  cur <= ZRUN_W'(rd_data);
      endcase
    end else if (state == S_EMIT && st.nib_ready) begin
      cur <= cur >> NIB_DATA_W;
    end
  end

  rvlc_packer u_packer (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .status      (st),
    .packed_word (packed_word),
    .last_word   (last_word),
    .word_valid  (word_valid),
    .word_stall  (word_stall)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= MAX_NONZERO_RUN)
    else $error("value count beyond run limit");

  a_fetch_phase: assert property (@(posedge clk) disable iff (rst)
    (state == S_FETCH) |-> (phase == PH_VAL))
    else $error("buffer fetch outside value phase");

  a_accept_next: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_LOAD || state == S_APPLY))
    else $error("accepted item not processed");

  a_frame_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_FLUSH && st.empty) |=> (state == S_IDLE && zero_run == '0 &&
                                        count == '0 && prev == '0))
    else $error("state not cleared at frame end");

endmodule

// ----- dv/rvl_depth_compressor_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvl_depth_compressor_core_tb
// self-checking bench for the rvl depth compressor: pixels go in through a
// valid/stall channel, and a cycle-free predictor builds the packed words each
// accepted pixel should produce. A monitor compares every accepted word and
// its frame-end flag, in order, against the predicted queue. Directed frames
// cover single pixels, word alignment, depth extremes and split runs. Random
// frames follow, with random gaps on the pixel channel and stalls on the word channel.
// ----------------------------------------------------------------------------
module rvl_depth_compressor_core_tb;
  import rvlc_pkg::*;

  localparam int CLK_HALF       = 10;
  localparam int RST_CYCLES     = 10;
  localparam int CYCLE_LIMIT    = 2000000;
  localparam int DRAIN_CYCLES   = 64;
  localparam int RANDOM_PIXELS  = 24;
  localparam int MAX_PRINTS     = 100;
  localparam int NIBS_PER_WORD  = 8;
  localparam int unsigned NIB_DATA = 32'h7;
  localparam logic [3:0] NIB_MORE  = 4'h8;

  typedef struct {
    logic [WORD_W-1:0] word;
    logic              last;
  } word_exp_t;

  logic                      clk         = 1'b0;
  logic                      rst         = 1'b1;
  logic signed [DEPTH_W-1:0] depth       = '0;
  logic                      last_pixel  = 1'b0;
  logic                      pixel_valid = 1'b0;
  logic                      pixel_stall;
  logic [WORD_W-1:0]         packed_word;
  logic                      last_word;
  logic                      word_valid;
  logic                      word_stall  = 1'b0;

  // predictor state
  int                prev_depth  = 0;
  int unsigned       zero_count  = 0;
  logic [ZZ_W-1:0]   zz_values [VBUF_DEPTH];
  int unsigned       value_total = 0;
  logic [PART_W-1:0] open_word   = '0;
  int unsigned       open_nibs   = 0;
  word_exp_t         expected_words [$];

  int errors     = 0;
  int cycles     = 0;
  int words_seen = 0;
  int stall_left = 0;
  bit no_idle    = 1'b0;

  rvl_depth_compressor_core i_dut (
    .clk         (clk),
    .rst         (rst),
    .depth       (depth),
    .last_pixel  (last_pixel),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .packed_word (packed_word),
    .last_word   (last_word),
    .word_valid  (word_valid),
    .word_stall  (word_stall)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= MAX_PRINTS) $display("ERROR @%0t: %s", $time, msg);
  endtask

  function automatic void add_expected(input logic [WORD_W-1:0] w);
    word_exp_t e;
    e.word = w;
    e.last = 1'b0;
    expected_words.insert(expected_words.size(), e);
  endfunction

  function automatic void pack_nibble(input logic [3:0] nib);
    logic [WORD_W-1:0] w;
    w = {open_word, nib};
    open_nibs++;
    if (open_nibs == NIBS_PER_WORD) begin
      add_expected(w);
      open_word = '0;
      open_nibs = 0;
    end else begin
      open_word = w[PART_W-1:0];
    end
  endfunction

  function automatic void pack_code(input int unsigned v);
    logic [3:0] nib;
    do begin
      nib = 4'(v & NIB_DATA);
      v = v >> 3;
      if (v != 0) nib = nib | NIB_MORE;
      pack_nibble(nib);
    end while (v != 0);
  endfunction

  function automatic void close_group();
    pack_code(zero_count);
    pack_code(value_total);
    for (int i = 0; i < value_total; i++) pack_code(zz_values[i]);
    zero_count  = 0;
    value_total = 0;
  endfunction

  function automatic void compress_pixel(input logic signed [DEPTH_W-1:0] d, input logic lp);
    int          diff;
    logic [31:0] du;
    logic [31:0] zz;
    logic [31:0] tail;
    int unsigned n_before;
    n_before = expected_words.size();
    if (d == 0) begin
      if (value_total != 0 || zero_count >= MAX_ZERO_RUN) close_group();
      zero_count++;
    end else begin
      if (value_total >= MAX_NONZERO_RUN) close_group();
      diff = int'(d) - prev_depth;
      du = diff;
      zz = (du << 1) ^ {32{diff < 0}};
      zz_values[value_total] = zz[ZZ_W-1:0];
      value_total++;
      prev_depth = d;
    end
    if (lp) begin
      if (zero_count != 0 || value_total != 0) close_group();
      if (open_nibs != 0) begin
        tail = {4'h0, open_word} << (4 * (NIBS_PER_WORD - open_nibs));
        add_expected(tail);
      end
      if (expected_words.size() > n_before) begin
        expected_words[expected_words.size() - 1].last = 1'b1;
      end
      prev_depth  = 0;
      zero_count  = 0;
      value_total = 0;
      open_word   = '0;
      open_nibs   = 0;
    end
  endfunction

  function automatic logic signed [DEPTH_W-1:0] pick_depth();
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 35) v = prev_depth + int'($urandom_range(0, 6)) - 3;
    else if (r < 55) v = prev_depth + int'($urandom_range(0, 120)) - 60;
    else if (r < 90) v = int'($urandom_range(0, 65535)) - 32768;
    else begin
      case ($urandom_range(0, 3))
        0:       v = 32767;
        1:       v = -32768;
        2:       v = 1;
        default: v = -1;
      endcase
    end
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    if (v == 0) v = 1;
    return v[DEPTH_W-1:0];
  endfunction

  task automatic send_pixel(input logic signed [DEPTH_W-1:0] d, input logic lp);
    int gap;
    gap = no_idle ? 0 : gap_len();
    if (gap > 0) begin
      pixel_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    depth       <= d;
    last_pixel  <= lp;
    pixel_valid <= 1'b1;
    do @(posedge clk); while (pixel_stall);
    compress_pixel(d, lp);
  endtask

  task automatic wait_drained();
    pixel_valid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  // word monitor
  always @(posedge clk) begin
    word_exp_t e;
    if (!rst && word_valid && !word_stall) begin
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word %08h last %b", packed_word, last_word));
      end else begin
        e = expected_words[0];
        expected_words.delete(0);
        if (packed_word !== e.word)
          report_mismatch($sformatf("word %0d: packed_word %08h, expected %08h",
                                    words_seen, packed_word, e.word));
        if (last_word !== e.last)
          report_mismatch($sformatf("word %0d: last_word %b, expected %b",
                                    words_seen, last_word, e.last));
      end
      words_seen++;
    end
  end

  // word channel back-pressure
  always @(posedge clk) begin
    if (rst) begin
      word_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      word_stall <= 1'b1;
      stall_left--;
    end else begin
      word_stall <= 1'b0;
      if (!no_idle) stall_left = gap_len();
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** rvl_depth_compressor_core: FAILED **");
      $finish;
    end
  end

  task automatic test_single_pixel_frames();
    send_pixel(16'sd5, 1'b1);
    send_pixel(16'sd0, 1'b1);
    send_pixel(-16'sd1, 1'b1);
  endtask

  // six one-nibble values fill exactly one word
  task automatic test_word_aligned_frame();
    send_pixel(16'sd1, 1'b0);
    send_pixel(16'sd2, 1'b0);
    send_pixel(16'sd3, 1'b0);
    send_pixel(16'sd3, 1'b0);
    send_pixel(16'sd2, 1'b0);
    send_pixel(16'sd1, 1'b1);
  endtask

  task automatic test_depth_extremes();
    send_pixel(16'sd0, 1'b0);
    send_pixel(16'sd32767, 1'b0);
    send_pixel(-16'sd32768, 1'b0);
    send_pixel(16'sd32767, 1'b0);
    send_pixel(16'sd0, 1'b0);
    send_pixel(16'sd0, 1'b0);
    send_pixel(-16'sd32768, 1'b0);
    send_pixel(-16'sd32768, 1'b0);
    send_pixel(16'sd1, 1'b0);
    send_pixel(-16'sd1, 1'b0);
    send_pixel(16'sd0, 1'b1);
  endtask

  // a full buffer, then one value past it to force a split
  task automatic test_long_nonzero_run();
    no_idle = 1'b1;
    for (int i = 0; i < 32; i++) send_pixel(DEPTH_W'(i * 37 - 500), i == 31);
    for (int i = 0; i < 33; i++) send_pixel(pick_depth(), i == 32);
    no_idle = 1'b0;
  endtask

  task automatic test_long_zero_run();
    repeat (66) send_pixel(16'sd0, 1'b0);
    send_pixel(-16'sd7, 1'b0);
    wait_drained();
    repeat (8) send_pixel(16'sd0, 1'b0);
    send_pixel(16'sd9, 1'b1);
  endtask

  task automatic test_random_frames();
    int sent;
    int zl;
    int nl;
    int r;
    bit end_frame;
    bit drained;
    sent    = 0;
    drained = 1'b0;
    while (sent < RANDOM_PIXELS) begin
      if ($urandom_range(0, 7) == 0) no_idle = !no_idle;
      if (!drained && sent >= RANDOM_PIXELS / 2) begin
        wait_drained();
        drained = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 30) zl = 0;
      else if (r < 75) zl = $urandom_range(1, 4);
      else if (r < 93) zl = $urandom_range(5, 20);
      else zl = $urandom_range(60, 130);
      r = $urandom_range(0, 99);
      if (r < 10) nl = 0;
      else if (r < 75) nl = $urandom_range(1, 6);
      else if (r < 92) nl = $urandom_range(7, 16);
      else nl = $urandom_range(30, 36);
      if (zl + nl == 0) nl = 1;
      end_frame = (sent + zl + nl >= RANDOM_PIXELS) || ($urandom_range(0, 3) == 0);
      for (int j = 0; j < zl + nl; j++)
        send_pixel(j < zl ? DEPTH_W'(0) : pick_depth(), end_frame && j == zl + nl - 1);
      sent += zl + nl;
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;
    test_single_pixel_frames();
    test_word_aligned_frame();
    test_depth_extremes();
    test_long_nonzero_run();
    test_long_zero_run();
    test_random_frames();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("** rvl_depth_compressor_core: PASSED **");
    end else begin
      $display("** rvl_depth_compressor_core: FAILED **");
    end
    $finish;
  end

endmodule
